// ===== hw/rtl/apsr_pkg.sv =====
// ----------------------------------------------------------------------------
// apsr_pkg
// shared types, constants and register codes of the allpass chain reverb
// ----------------------------------------------------------------------------
package apsr_pkg;

   // default sizes
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int DELAY_DEPTH_DEF = 1024;

   // register field widths
   localparam int GAIN_BITS = 16;
   localparam int ROOM_BITS = 10;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROOM_SIZE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK_GAIN = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DAMPING_GAIN  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRY_GAIN      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET_GAIN      = 3'd4;

   // register reset values
   localparam logic [ROOM_BITS-1:0] ROOM_SIZE_RST     = 10'd256;
   localparam logic [GAIN_BITS-1:0] FEEDBACK_GAIN_RST = 16'd52429;
   localparam logic [GAIN_BITS-1:0] DAMPING_GAIN_RST  = 16'd3277;
   localparam logic [GAIN_BITS-1:0] DRY_GAIN_RST      = 16'd32768;
   localparam logic [GAIN_BITS-1:0] WET_GAIN_RST      = 16'd16384;

   // allpass stages and their base taps
   localparam int NUM_STAGES = 4;
   localparam int TAP_BITS   = 9;
   localparam logic [TAP_BITS-1:0] TAP_BASE [NUM_STAGES] = '{9'd107, 9'd142, 9'd277, 9'd379};

   // width of floor(base * room_size / 256)
   localparam int OFF_BITS = TAP_BITS + ROOM_BITS - 8;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WET_MUL,
      ST_DIFF,
      ST_DAMP_MUL,
      ST_DAMP,
      ST_AP0_SUB,
      ST_AP0_ADD,
      ST_AP1_SUB,
      ST_AP1_ADD,
      ST_AP2_SUB,
      ST_AP2_ADD,
      ST_LEFT,
      ST_AP3_SUB,
      ST_AP3_ADD,
      ST_RIGHT
   } apsr_state_type;

endpackage

// ===== hw/rtl/apsr_req_if.sv =====
// ----------------------------------------------------------------------------
// apsr_req_if
// input frame channel: valid/ready with one stereo frame
// ----------------------------------------------------------------------------
interface apsr_req_if import apsr_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ===== hw/rtl/apsr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// apsr_rsp_if
// result frame channel: valid/ready with one stereo frame
// ----------------------------------------------------------------------------
interface apsr_rsp_if import apsr_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== hw/rtl/apsr_ram.sv =====
// ----------------------------------------------------------------------------
// apsr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module apsr_ram import apsr_pkg::*; #(
   parameter int WIDTH = SAMPLE_BITS_DEF,
   parameter int DEPTH = DELAY_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/allpass_chain_stereo_reverb_unit.sv =====
// ----------------------------------------------------------------------------
// allpass_chain_stereo_reverb_unit
// four stage allpass ambience reverb on stereo q1.23 frames
// ----------------------------------------------------------------------------
// usage
// - req_ch carries one stereo frame per transfer (left_in, right_in); rsp_ch
//   carries the matching reverberated frame (left_out, right_out), one result
//   per input frame, in order
// - csr_we/csr_index/csr_wdata write the five gain and size registers; write
//   them only while no frame is in flight
// - one shared 25x17 multiplier and a sequencer do all the arithmetic: an
//   accepted frame walks through 14 sequencer steps, and rsp_ch.valid rises
//   once the last step, ST_RIGHT, loads the output register; a new frame is
//   taken only once the sequencer is through with the previous one
// - req_ch.ready is high only while the sequencer is idle
// - the result sits in an output register; a new frame is accepted while it
//   waits, and if it still waits when the next result is done, the sequencer
//   holds its last step until rsp_ch.ready
// - reset (synchronous) restores register defaults, zeroes the damping state
//   and the read position, and then sweeps zeros through all four delay
//   memories, one address per cycle; during the sweep req_ch.ready is low
// ----------------------------------------------------------------------------
module allpass_chain_stereo_reverb_unit import apsr_pkg::*; #(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   apsr_req_if.sink                  req_ch,
   apsr_rsp_if.source                rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);
   localparam int SB = SAMPLE_BITS;
   localparam int AW = $clog2(DELAY_DEPTH);
   // multiplier operands: sample plus one bit, unsigned gain plus sign
   localparam int MA = SB + 1;
   localparam int MB = GAIN_BITS + 1;
   localparam int PW = MA + MB;
   // width for the write address wrap arithmetic
   localparam int CW = ((AW > OFF_BITS) ? AW : OFF_BITS) + 2;
   localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
   // saturation bounds at product width
   localparam logic signed [PW-1:0] SMP_MAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [PW-1:0] SMP_MIN = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};

   function automatic logic signed [SB-1:0] sat_f(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] c;
      if (v > SMP_MAX) begin
         c = SMP_MAX;
      end else if (v < SMP_MIN) begin
         c = SMP_MIN;
      end else begin
         c = v;
      end
      return c[SB-1:0];
   endfunction

   // sequencer and datapath registers
   apsr_state_type state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;      // clearing sweep address
   logic [AW-1:0]           rp_ff, rp_in;        // delay read position
   logic [AW-1:0]           wpos_ff, wpos_in;    // current stage write address
   logic signed [SB-1:0]    a_ff, a_in;          // latched left input
   logic signed [SB-1:0]    b_ff, b_in;          // latched right input
   logic signed [SB-1:0]    damped_ff, damped_in;
   logic signed [SB-1:0]    r_ff, r_in;          // signal through the chain
   logic signed [MA-1:0]    diff_ff, diff_in;    // wet minus damped level
   logic signed [SB-1:0]    left_res_ff, left_res_in;
   logic signed [PW-1:0]    prod_ff;
   logic signed [SB-1:0]    out_left_ff, out_left_in;
   logic signed [SB-1:0]    out_right_ff, out_right_in;
   logic                    out_valid_ff, out_valid_in;

   // configuration registers
   logic [ROOM_BITS-1:0] room_ff, room_in;
   logic [GAIN_BITS-1:0] fb_ff, fb_in;
   logic [GAIN_BITS-1:0] damp_gain_ff, damp_gain_in;
   logic [GAIN_BITS-1:0] dry_ff, dry_in;
   logic [GAIN_BITS-1:0] wet_ff, wet_in;

   // shared multiplier controls
   logic                 mul_en;
   logic signed [MA-1:0] mul_a;
   logic signed [MB-1:0] mul_b;

   // delay memories
   logic [NUM_STAGES-1:0] ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [SB-1:0]         ram_wdata;
   logic                  ram_re;
   logic [SB-1:0]         ram_rdata [NUM_STAGES];

   // post-multiply values
   logic signed [PW-1:0] p_sh15, p_sh16;
   logic [OFF_BITS-1:0]  off_raw;
   logic [CW-1:0]        off0, off1, off2, wsum, wsum_m;
   logic [AW-1:0]        wpos_new;
   logic [1:0]           tsel;
   logic signed [SB-1:0] t_cur;
   logic signed [SB-1:0] wet_v, damp_v, sub_v, add_v, out_v;
   logic signed [MA-1:0] diff_v;
   logic                 accept, out_free;

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_delay
      apsr_ram #(
         .WIDTH (SB),
         .DEPTH (DELAY_DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (ram_we[k]),
         .waddr (ram_waddr),
         .wdata (ram_wdata),
         .re    (ram_re),
         .raddr (rp_ff),
         .rdata (ram_rdata[k])
      );
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign accept           = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.left_out  = out_left_ff;
   assign rsp_ch.right_out = out_right_ff;
   // output register is free or being emptied this cycle
   assign out_free         = !out_valid_ff || rsp_ch.ready;

   // shifted products, floor rounding by arithmetic shift
   assign p_sh15  = prod_ff >>> 15;
   assign p_sh16  = prod_ff >>> 16;
   assign off_raw = prod_ff[8 +: OFF_BITS];

   // write address = (read position + offset) mod depth; offset < 3 * depth
   always_comb begin
      off0     = CW'(off_raw);
      off1     = (off0 >= DEPTH_C) ? (off0 - DEPTH_C) : off0;
      off2     = (off1 >= DEPTH_C) ? (off1 - DEPTH_C) : off1;
      wsum     = off2 + CW'(rp_ff);
      wsum_m   = (wsum >= DEPTH_C) ? (wsum - DEPTH_C) : wsum;
      wpos_new = wsum_m[AW-1:0];
   end

   // tap word of the stage that finishes its allpass
   always_comb begin
      unique case (state_ff)
         ST_AP1_ADD: tsel = 2'd1;
         ST_AP2_ADD: tsel = 2'd2;
         ST_AP3_ADD: tsel = 2'd3;
         default:    tsel = 2'd0;
      endcase
      t_cur = $signed(ram_rdata[tsel]);
   end

   always_comb begin
      wet_v  = sat_f(p_sh15);
      diff_v = MA'(wet_v) - MA'(damped_ff);
      damp_v = sat_f(PW'(damped_ff) + p_sh16);
      sub_v  = sat_f(PW'(r_ff) - p_sh16);
      add_v  = sat_f(PW'(r_ff) + PW'(t_cur));
      out_v  = sat_f(p_sh15 + PW'(r_ff) - PW'(damped_ff));
   end

   // configuration writes
   always_comb begin
      room_in      = room_ff;
      fb_in        = fb_ff;
      damp_gain_in = damp_gain_ff;
      dry_in       = dry_ff;
      wet_in       = wet_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROOM_SIZE:     room_in      = csr_wdata[ROOM_BITS-1:0];
            CSR_FEEDBACK_GAIN: fb_in        = csr_wdata[GAIN_BITS-1:0];
            CSR_DAMPING_GAIN:  damp_gain_in = csr_wdata[GAIN_BITS-1:0];
            CSR_DRY_GAIN:      dry_in       = csr_wdata[GAIN_BITS-1:0];
            CSR_WET_GAIN:      wet_in       = csr_wdata[GAIN_BITS-1:0];
            default:           ;  // unknown index, write dropped
         endcase
      end
   end

   // sequencer: the steps from ST_WET_MUL to ST_AP3_SUB each issue one multiply; later steps consume the products
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rp_in        = rp_ff;
      wpos_in      = wpos_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      damped_in    = damped_ff;
      r_in         = r_ff;
      diff_in      = diff_ff;
      left_res_in  = left_res_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      ram_we       = '0;
      ram_waddr    = wpos_ff;
      ram_wdata    = sub_v;
      ram_re       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = '1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               a_in     = req_ch.left_in;
               b_in     = req_ch.right_in;
               ram_re   = 1'b1;   // fetch all four taps at the read position
               state_in = ST_WET_MUL;
            end
         end
         ST_WET_MUL: begin
            mul_en   = 1'b1;
            mul_a    = MA'(a_ff) + MA'(b_ff);
            mul_b    = $signed({1'b0, wet_ff});
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = diff_v;
            mul_en   = 1'b1;
            mul_a    = MA'(TAP_BASE[0]);
            mul_b    = MB'(room_ff);
            state_in = ST_DAMP_MUL;
         end
         ST_DAMP_MUL: begin
            wpos_in  = wpos_new;
            mul_en   = 1'b1;
            mul_a    = diff_ff;
            mul_b    = $signed({1'b0, damp_gain_ff});
            state_in = ST_DAMP;
         end
         ST_DAMP: begin
            damped_in = damp_v;
            r_in      = damp_v;
            mul_en    = 1'b1;
            mul_a     = MA'($signed(ram_rdata[0]));
            mul_b     = $signed({1'b0, fb_ff});
            state_in  = ST_AP0_SUB;
         end
         ST_AP0_SUB: begin
            r_in      = sub_v;
            ram_we[0] = 1'b1;
            mul_en    = 1'b1;
            mul_a     = MA'(TAP_BASE[1]);
            mul_b     = MB'(room_ff);
            state_in  = ST_AP0_ADD;
         end
         ST_AP0_ADD: begin
            r_in     = add_v;
            wpos_in  = wpos_new;
            mul_en   = 1'b1;
            mul_a    = MA'($signed(ram_rdata[1]));
            mul_b    = $signed({1'b0, fb_ff});
            state_in = ST_AP1_SUB;
         end
         ST_AP1_SUB: begin
            r_in      = sub_v;
            ram_we[1] = 1'b1;
            mul_en    = 1'b1;
            mul_a     = MA'(TAP_BASE[2]);
            mul_b     = MB'(room_ff);
            state_in  = ST_AP1_ADD;
         end
         ST_AP1_ADD: begin
            r_in     = add_v;
            wpos_in  = wpos_new;
            mul_en   = 1'b1;
            mul_a    = MA'($signed(ram_rdata[2]));
            mul_b    = $signed({1'b0, fb_ff});
            state_in = ST_AP2_SUB;
         end
         ST_AP2_SUB: begin
            r_in      = sub_v;
            ram_we[2] = 1'b1;
            mul_en    = 1'b1;
            mul_a     = MA'(TAP_BASE[3]);
            mul_b     = MB'(room_ff);
            state_in  = ST_AP2_ADD;
         end
         ST_AP2_ADD: begin
            r_in     = add_v;
            wpos_in  = wpos_new;
            mul_en   = 1'b1;
            mul_a    = MA'(a_ff);
            mul_b    = $signed({1'b0, dry_ff});
            state_in = ST_LEFT;
         end
         ST_LEFT: begin
            // left taps the chain after the third stage
            left_res_in = out_v;
            mul_en      = 1'b1;
            mul_a       = MA'($signed(ram_rdata[3]));
            mul_b       = $signed({1'b0, fb_ff});
            state_in    = ST_AP3_SUB;
         end
         ST_AP3_SUB: begin
            r_in      = sub_v;
            ram_we[3] = 1'b1;
            mul_en    = 1'b1;
            mul_a     = MA'(b_ff);
            mul_b     = $signed({1'b0, dry_ff});
            state_in  = ST_AP3_ADD;
         end
         ST_AP3_ADD: begin
            r_in     = add_v;
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            // hold here while the previous result still waits
            if (out_free) begin
               out_left_in  = left_res_ff;
               out_right_in = out_v;
               out_valid_in = 1'b1;
               rp_in        = (rp_ff == LAST_ADDR) ? '0 : (rp_ff + 1'b1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rp_ff        <= '0;
         damped_ff    <= '0;
         out_valid_ff <= 1'b0;
         room_ff      <= ROOM_SIZE_RST;
         fb_ff        <= FEEDBACK_GAIN_RST;
         damp_gain_ff <= DAMPING_GAIN_RST;
         dry_ff       <= DRY_GAIN_RST;
         wet_ff       <= WET_GAIN_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rp_ff        <= rp_in;
         damped_ff    <= damped_in;
         out_valid_ff <= out_valid_in;
         room_ff      <= room_in;
         fb_ff        <= fb_in;
         damp_gain_ff <= damp_gain_in;
         dry_ff       <= dry_in;
         wet_ff       <= wet_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wpos_ff      <= wpos_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      r_ff         <= r_in;
      diff_ff      <= diff_in;
      left_res_ff  <= left_res_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

endmodule

// ===== bench/tb_allpass_chain_stereo_reverb_unit.sv =====
// ----------------------------------------------------------------------------
// tb_allpass_chain_stereo_reverb_unit
// self-checking bench for the four stage allpass stereo reverb
// ----------------------------------------------------------------------------
// stereo frames go in on the request channel and every reverberated frame is
// checked against a cycle-free predictor of the damping filter and the four
// allpass delay lines. directed frames cover the sample extremes, default
// and extreme register values, zero and wrapped tap offsets, ignored
// register indexes and oversized register data. random frames then run under
// many register settings while both channel ends idle at varying rates.
// ----------------------------------------------------------------------------
module tb_allpass_chain_stereo_reverb_unit;
   import apsr_pkg::*;

   localparam int SAMPLE_W = SAMPLE_BITS_DEF;
   localparam int DEPTH    = DELAY_DEPTH_DEF;
   localparam longint SMP_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SMP_MIN = -SMP_MAX - 1;
   localparam int TAPS [4] = '{107, 142, 277, 379};

   // clearing sweep after reset plus 1625 frames at worst-case pacing fits
   // well under this
   localparam int CYCLE_LIMIT = 900000;
   // extra wait at the end so that a stray late result is still caught
   localparam int SETTLE_CYCLES = 32;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct {
      sample_type left;
      sample_type right;
   } stereo_frame_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   apsr_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_ch ();
   apsr_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_ch ();

   allpass_chain_stereo_reverb_unit #(
      .DELAY_DEPTH(DEPTH),
      .SAMPLE_BITS(SAMPLE_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor state: register copies, damping filter and delay lines
   // ---------------------------------------------------------------------
   logic [ROOM_BITS-1:0] room_size;
   logic [GAIN_BITS-1:0] feedback_gain;
   logic [GAIN_BITS-1:0] damping_gain;
   logic [GAIN_BITS-1:0] dry_gain;
   logic [GAIN_BITS-1:0] wet_gain;
   longint damped_level;
   int tap_read_pos;
   sample_type echo_mem [4][DEPTH];

   // reverberated frames still owed by the block, oldest first
   stereo_frame_type reverb_frames_due [$];

   // pacing, in percent of cycles
   int sender_idle_pct;
   int sink_stall_pct;

   int error_count;
   int frames_checked;
   int settings_used;
   int cycle_count;

   function automatic longint clamp_sample(input longint v);
      if (v > SMP_MAX) return SMP_MAX;
      if (v < SMP_MIN) return SMP_MIN;
      return v;
   endfunction

   // one allpass stage: read the old word first, then write the new one at
   // the scaled tap offset (which may land on the read slot or wrap)
   function automatic longint allpass_stage(input int k, input longint x);
      int offset;
      int wpos;
      longint tap;
      offset = (TAPS[k] * int'(room_size)) >> 8;
      wpos = (tap_read_pos + offset) % DEPTH;
      tap = echo_mem[k][tap_read_pos];
      x = clamp_sample(x - ((tap * longint'(feedback_gain)) >>> 16));
      echo_mem[k][wpos] = sample_type'(x);
      return clamp_sample(x + tap);
   endfunction

   // advance the reverb by one frame and return the frame it should emit
   function automatic stereo_frame_type compute_reverb_frame(input sample_type l,
                                                             input sample_type r);
      longint a;
      longint b;
      longint wet;
      longint x;
      stereo_frame_type res;
      a = l;
      b = r;
      wet = clamp_sample(((a + b) * longint'(wet_gain)) >>> 15);
      damped_level = clamp_sample(damped_level +
                                  (((wet - damped_level) * longint'(damping_gain)) >>> 16));
      x = damped_level;
      for (int k = 0; k < 3; k++) x = allpass_stage(k, x);
      res.left = sample_type'(clamp_sample(((a * longint'(dry_gain)) >>> 15) + x -
                                           damped_level));
      x = allpass_stage(3, x);
      res.right = sample_type'(clamp_sample(((b * longint'(dry_gain)) >>> 15) + x -
                                            damped_level));
      tap_read_pos = (tap_read_pos + 1) % DEPTH;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // result side: random back-pressure and the in-order checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      stereo_frame_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reverb_frames_due.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result frame left %0d right %0d", $time,
                     rsp_ch.left_out, rsp_ch.right_out);
         end else begin
            want = reverb_frames_due.pop_front();
            frames_checked++;
            if (rsp_ch.left_out !== want.left) begin
               error_count++;
               $display("%0t: left_out mismatch, expected %0d, got %0d", $time,
                        want.left, rsp_ch.left_out);
            end
            if (rsp_ch.right_out !== want.right) begin
               error_count++;
               $display("%0t: right_out mismatch, expected %0d, got %0d", $time,
                        want.right, rsp_ch.right_out);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d frames outstanding", $time,
                  reverb_frames_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // one frame transfer; valid stays up afterwards so back-to-back frames
   // need no second assignment in the same step
   task automatic send_frame(input sample_type l, input sample_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.left_in <= l;
      req_ch.right_in <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // transfer done at this edge; the predictor follows the same order
      reverb_frames_due.push_back(compute_reverb_frame(l, r));
   endtask

   // stop sending and wait until every owed frame came back
   task automatic wait_frames_drained();
      req_ch.valid <= 1'b0;
      while (reverb_frames_due.size() != 0) @(posedge clock);
   endtask

   // register write; csr_we is left high for a following write
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ROOM_SIZE:     room_size = val[ROOM_BITS-1:0];
         CSR_FEEDBACK_GAIN: feedback_gain = val;
         CSR_DAMPING_GAIN:  damping_gain = val;
         CSR_DRY_GAIN:      dry_gain = val;
         CSR_WET_GAIN:      wet_gain = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // full register set, only while the block is idle
   task automatic configure(input logic [CSR_DATA_BITS-1:0] room, input logic [15:0] fb,
                            input logic [15:0] damp, input logic [15:0] dry,
                            input logic [15:0] wet);
      wait_frames_drained();
      write_csr(CSR_ROOM_SIZE, room);
      write_csr(CSR_FEEDBACK_GAIN, fb);
      write_csr(CSR_DAMPING_GAIN, damp);
      write_csr(CSR_DRY_GAIN, dry);
      write_csr(CSR_WET_GAIN, wet);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0: return sample_type'(SMP_MAX);
         1: return sample_type'(SMP_MIN);
         2: return sample_type'(int'($urandom_range(0, 511)) - 256);
         3: return sample_type'(int'($urandom_range(0, 65535)) - 32768);
         default: return sample_type'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // room sizes: zero (write on the read slot), the top code (wrapped
   // offsets), the usual range, and junk above the field width
   function automatic logic [15:0] pick_room();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'h03FF;
         2: return 16'd687;
         3: return {6'($urandom()), 10'($urandom_range(0, 1023))};
         default: return 16'($urandom_range(0, 687));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic apply_reset();
      sender_idle_pct = 35;
      sink_stall_pct = 83;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.left_in <= '0;
      req_ch.right_in <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      room_size = ROOM_SIZE_RST;
      feedback_gain = FEEDBACK_GAIN_RST;
      damping_gain = DAMPING_GAIN_RST;
      dry_gain = DRY_GAIN_RST;
      wet_gain = WET_GAIN_RST;
      damped_level = 0;
      tap_read_pos = 0;
      foreach (echo_mem[k, i]) echo_mem[k][i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // delay memories are swept clear before the first frame is taken
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // sample extremes under the reset register values
   task automatic test_default_registers();
      send_frame(sample_type'(SMP_MAX), sample_type'(SMP_MAX));
      send_frame(sample_type'(SMP_MIN), sample_type'(SMP_MIN));
      send_frame(sample_type'(SMP_MAX), sample_type'(SMP_MIN));
      send_frame(sample_type'(SMP_MIN), sample_type'(SMP_MAX));
      send_frame('0, '0);
      send_frame(sample_type'(1), sample_type'(-1));
      wait_frames_drained();
   endtask

   // all gains at full scale, room zero so each stage writes where it reads
   task automatic test_full_gain_zero_room();
      configure(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_frame(sample_type'(SMP_MAX), sample_type'(SMP_MAX));
      send_frame(sample_type'(SMP_MIN), sample_type'(SMP_MIN));
      send_frame(sample_type'(SMP_MAX), sample_type'(SMP_MIN));
      send_frame(sample_type'(12345), sample_type'(-54321));
      send_frame('0, '0);
      wait_frames_drained();
   endtask

   // zero gains with the largest room, whose taps wrap past the memory end
   task automatic test_zero_gain_wrapped_room();
      configure(16'h03FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_frame(sample_type'(SMP_MAX), sample_type'(SMP_MIN));
      send_frame(sample_type'(SMP_MIN), sample_type'(SMP_MAX));
      send_frame(sample_type'(-7), sample_type'(7));
      send_frame(sample_type'(SMP_MAX), sample_type'(SMP_MAX));
      wait_frames_drained();
   endtask

   // writes to unused indexes change nothing; room bits above the field drop
   task automatic test_ignored_writes();
      configure(16'hFC00 | 16'd300, 16'd40000, 16'd9000, 16'd30000, 16'd20000);
      for (int i = int'(CSR_WET_GAIN) + 1; i < (1 << CSR_INDEX_BITS); i++) begin
         write_csr(CSR_INDEX_BITS'(i), 16'hFFFF);
      end
      csr_we <= 1'b0;
      send_frame(sample_type'(SMP_MAX), sample_type'(SMP_MAX));
      send_frame(sample_type'(SMP_MIN), sample_type'(123456));
      send_frame(sample_type'(-4000000), sample_type'(4000000));
      send_frame(sample_type'(1), sample_type'(0));
      send_frame(sample_type'(SMP_MIN), sample_type'(SMP_MIN));
      wait_frames_drained();
   endtask

   // random frames over several register settings at one pacing mode
   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input int settings, input int frames_each);
      sender_idle_pct = send_pct;
      sink_stall_pct = stall_pct;
      for (int s = 0; s < settings; s++) begin
         configure(pick_room(), pick_gain(), pick_gain(), pick_gain(), pick_gain());
         for (int i = 0; i < frames_each; i++) begin
            // sender holds off mid-setting until the pipeline is empty
            if (i == frames_each / 2) wait_frames_drained();
            send_frame(pick_sample(), pick_sample());
         end
      end
      wait_frames_drained();
   endtask

   initial begin
      error_count = 0;
      frames_checked = 0;
      settings_used = 1;
      cycle_count = 0;
      apply_reset();

      test_default_registers();
      test_full_gain_zero_room();
      test_zero_gain_wrapped_room();
      test_ignored_writes();

      test_random_traffic(35, 83, 5, 107);
      test_random_traffic(83, 35, 5, 107);
      test_random_traffic(0, 0, 5, 107);

      // a stray late result would still be caught here
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d reverb frames under %0d register settings,", frames_checked,
               settings_used);
      $display("with sample extremes, zero and wrapped taps and three pacing modes");
      if (error_count == 0 && reverb_frames_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
